// ----- sv/ppm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_pkg: shared types and constants
// Types, codes and limits for the ASCII PPM (P3) decoder.
// ----------------------------------------------------------------------------
package ppm_pkg;

    localparam logic [31:0] MAX_DIM   = 32'd4096;
    localparam logic [32:0] LIMIT_NEG = 33'h0_8000_0000;

    typedef enum logic [2:0] {
        PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAX, PH_PIXELS, PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        TM_BETWEEN, TM_TOKEN, TM_COMMENT, TM_SKIPLINE
    } t_tmode;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0, KIND_PIXEL = 2'd1, KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_MAGIC = 3'd0, ERR_NUMBER = 3'd1, ERR_NONPOS = 3'd2,
        ERR_TRUNC = 3'd3, ERR_LARGE = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FIN, ST_DIV, ST_EOF, ST_EMIT
    } t_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [12:0] width_out;
        logic [12:0] height_out;
        logic        final_pixel;
        logic [2:0]  error_code;
        logic        run_end;
    } t_out;

    // divider control
    typedef struct packed {
        logic        start;
        logic [39:0] dividend;
        logic [30:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] quot;
    } t_div_rsp;

endpackage

// ----- sv/ppm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_in_if / ppm_out_if: valid/ready channels
// Handshake channels carrying input bytes and result items.
// ----------------------------------------------------------------------------
interface ppm_in_if import ppm_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppm_out_if import ppm_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/ppm_ascii_image_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_ascii_image_decoder_unit: ASCII PPM (P3) byte-stream decoder
// Tokenizes P3 text, checks the header and emits scaled RGBA pixels.
// ----------------------------------------------------------------------------
// Channel   | Dir | Payload
// i_in      | in  | data_byte[7:0], last_byte
// o_out     | out | kind, rgba, width/height, final_pixel, error_code, run_end
//
// A byte that ends nothing leaves the unit idle and ready. A byte that ends a token
// passes through an evaluation state and an output state before the next byte
// is taken. A positive colour token also waits in a divide state for the shared
// divider (load + nine steps). The last byte passes through an end-of-file
// state for the truncation check and clear. A byte causes at most two items;
// input is held off until every item is taken. Reset clears all control and
// parse state.
// ----------------------------------------------------------------------------
module ppm_ascii_image_decoder_unit import ppm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ppm_in_if.sink    i_in,
    ppm_out_if.source o_out
);
    t_state r_st, n_st;
    t_phase r_ph;
    t_tmode r_tm;
    logic [1:0]  r_mp;
    logic        r_neg, r_dseen, r_dend, r_ovf;
    logic [31:0] r_mag;
    logic [12:0] r_w, r_h;
    logic [30:0] r_max;
    logic [24:0] r_left;
    logic [1:0]  r_ch;
    logic [7:0]  r_red, r_grn;
    logic        r_last;
    // items caused by the current byte, oldest at index 0
    t_out        r_q [2];
    logic [1:0]  r_n;

    t_div_req w_req;
    t_div_rsp w_rsp;

    logic [7:0]  w_c;
    logic        w_ws, w_dig, w_sign, w_acc, w_fin;
    logic [35:0] w_ten;
    logic        w_valid, w_nonpos, w_big, w_divgo, w_apply;
    logic [25:0] w_area;
    logic [24:0] w_left_nx;
    logic [7:0]  w_val;
    t_out        w_pix, w_hdr, w_head;

    ppm_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign w_c    = i_in.data.data_byte;
    assign w_ws   = (w_c == 8'h20) || (w_c >= 8'd9 && w_c <= 8'd13);
    assign w_dig  = (w_c >= "0") && (w_c <= "9");
    assign w_sign = (w_c == "+") || (w_c == "-");
    assign w_acc  = i_in.valid && i_in.ready;

    // token ends on whitespace or at the last byte, also one that opens on the last byte
    assign w_fin = (r_tm == TM_TOKEN && (w_ws || i_in.data.last_byte)) ||
                   (r_tm == TM_BETWEEN && !w_ws && w_c != "#" && i_in.data.last_byte);

    // magnitude*10 + digit, checked against 2^31
    assign w_ten = {1'b0, r_mag, 3'd0} + {3'd0, r_mag, 1'b0} + {32'd0, w_c[3:0]};

    // token-end checks on the registered number
    assign w_valid  = r_dseen && !r_ovf && (r_neg || r_mag < 32'h8000_0000);
    assign w_nonpos = r_neg || (r_mag == 32'd0);
    assign w_big    = (r_mag > MAX_DIM);
    assign w_area   = {13'd0, r_w} * {13'd0, r_h};

    // colour value: divider quotient, or zero for zero/negative tokens
    assign w_divgo   = (r_ph == PH_PIXELS) && w_valid && !w_nonpos;
    assign w_apply   = (r_st == ST_FIN && r_ph == PH_PIXELS && w_valid && w_nonpos) ||
                       (r_st == ST_DIV && w_rsp.done);
    assign w_val     = (r_st == ST_DIV) ? w_rsp.quot : 8'd0;
    assign w_left_nx = (r_left == 25'd0) ? 25'd0 : r_left - 25'd1;

    function automatic t_out mk_err(input t_err e);
        t_out o;
        o = '0;
        o.kind = KIND_ERROR;
        o.error_code = e;
        return o;
    endfunction

    always_comb begin
        w_pix = '0;
        w_pix.kind  = KIND_PIXEL;
        w_pix.red   = r_red;
        w_pix.green = r_grn;
        w_pix.blue  = w_val;
        w_pix.alpha = (r_red == 8'd0 && r_grn == 8'd0 && w_val == 8'd0) ? 8'd0 : 8'd255;
        w_pix.final_pixel = (w_left_nx == 25'd0);
        w_hdr = '0;
        w_hdr.kind       = KIND_HEADER;
        w_hdr.width_out  = r_w;
        w_hdr.height_out = r_h;
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (w_acc) begin
                    if (w_fin) n_st = ST_FIN;
                    else if (i_in.data.last_byte) n_st = ST_EOF;
                end
            end
            ST_FIN: begin
                if (w_divgo) n_st = ST_DIV;
                else if (r_last) n_st = ST_EOF;
                else n_st = ST_EMIT;
            end
            ST_DIV: begin
                if (w_rsp.done) n_st = r_last ? ST_EOF : ST_EMIT;
            end
            ST_EOF:  n_st = ST_EMIT;
            ST_EMIT: begin
                if (r_n == 2'd0 || (r_n == 2'd1 && o_out.ready)) n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        w_req.start    = (r_st == ST_FIN) && w_divgo;
        w_req.dividend = {r_mag, 8'd0} - {8'd0, r_mag};
        w_req.divisor  = r_max;
        i_in.ready     = (r_st == ST_IDLE);
        o_out.valid    = (r_st == ST_EMIT) && (r_n != 2'd0);
        w_head         = r_q[0];
        w_head.run_end = (r_n == 2'd1);
        o_out.data     = w_head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_ph <= PH_MAGIC; r_tm <= TM_BETWEEN;
            r_mp <= '0; r_neg <= 1'b0; r_dseen <= 1'b0; r_dend <= 1'b0; r_ovf <= 1'b0;
            r_mag <= '0; r_w <= '0; r_h <= '0; r_max <= '0; r_left <= '0;
            r_ch <= '0; r_red <= '0; r_grn <= '0; r_n <= 2'd0; r_last <= 1'b0;
        end else begin
            r_st <= n_st;
            case (r_st)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_last <= i_in.data.last_byte;
                        case (r_tm)
                            TM_BETWEEN: begin
                                if (!w_ws) begin
                                    if (w_c == "#") begin
                                        r_tm <= TM_COMMENT;
                                    end else begin
                                        r_tm    <= TM_TOKEN;
                                        r_mp    <= (w_c == "P") ? 2'd1 : 2'd3;
                                        r_neg   <= (w_c == "-");
                                        r_dseen <= w_dig;
                                        r_dend  <= !w_dig && !w_sign;
                                        r_ovf   <= 1'b0;
                                        r_mag   <= w_dig ? {28'd0, w_c[3:0]} : 32'd0;
                                    end
                                end
                            end
                            TM_TOKEN: begin
                                if (w_ws) begin
                                    r_tm <= TM_BETWEEN;
                                end else begin
                                    r_mp <= (r_mp == 2'd1 && w_c == "3") ? 2'd2 : 2'd3;
                                    if (!r_dend) begin
                                        if (!w_dig) begin
                                            r_dend <= 1'b1;
                                        end else begin
                                            r_dseen <= 1'b1;
                                            if (!r_ovf) begin
                                                if (w_ten > {3'd0, LIMIT_NEG}) r_ovf <= 1'b1;
                                                else r_mag <= w_ten[31:0];
                                            end
                                        end
                                    end
                                end
                            end
                            TM_COMMENT: begin
                                if (w_ws) r_tm <= (w_c == 8'h0A) ? TM_BETWEEN : TM_SKIPLINE;
                            end
                            default: begin
                                if (w_c == 8'h0A) r_tm <= TM_BETWEEN;
                            end
                        endcase
                    end
                end
                ST_FIN: begin
                    // checks in order: bad number, nonpositive, too large
                    case (r_ph)
                        PH_MAGIC: begin
                            if (r_mp == 2'd2) begin
                                r_ph <= PH_WIDTH;
                            end else begin
                                r_q[0] <= mk_err(ERR_MAGIC); r_n <= 2'd1; r_ph <= PH_DONE;
                            end
                        end
                        PH_WIDTH, PH_HEIGHT, PH_MAX: begin
                            if (!w_valid) begin
                                r_q[0] <= mk_err(ERR_NUMBER); r_n <= 2'd1; r_ph <= PH_DONE;
                            end else if (w_nonpos) begin
                                r_q[0] <= mk_err(ERR_NONPOS); r_n <= 2'd1; r_ph <= PH_DONE;
                            end else if (r_ph != PH_MAX && w_big) begin
                                r_q[0] <= mk_err(ERR_LARGE); r_n <= 2'd1; r_ph <= PH_DONE;
                            end else if (r_ph == PH_WIDTH) begin
                                r_w <= r_mag[12:0]; r_ph <= PH_HEIGHT;
                            end else if (r_ph == PH_HEIGHT) begin
                                r_h <= r_mag[12:0]; r_ph <= PH_MAX;
                            end else begin
                                r_max  <= r_mag[30:0];
                                r_left <= w_area[24:0];
                                r_ch   <= 2'd0;
                                r_ph   <= PH_PIXELS;
                                r_q[0] <= w_hdr; r_n <= 2'd1;
                            end
                        end
                        PH_PIXELS: begin
                            if (!w_valid) begin
                                r_q[0] <= mk_err(ERR_NUMBER); r_n <= 2'd1; r_ph <= PH_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_EOF: begin
                    // file ended before the last pixel with no error yet
                    if (r_ph != PH_DONE) begin
                        r_q[r_n[0]] <= mk_err(ERR_TRUNC);
                        r_n <= r_n + 2'd1;
                    end
                    r_ph <= PH_MAGIC; r_tm <= TM_BETWEEN; r_mp <= '0; r_neg <= 1'b0;
                    r_dseen <= 1'b0; r_dend <= 1'b0; r_ovf <= 1'b0; r_mag <= '0;
                    r_w <= '0; r_h <= '0; r_max <= '0; r_left <= '0; r_ch <= '0;
                    r_red <= '0; r_grn <= '0; r_last <= 1'b0;
                end
                ST_EMIT: begin
                    if (o_out.valid && o_out.ready) begin
                        r_q[0] <= r_q[1];
                        r_n    <= r_n - 2'd1;
                    end
                end
                default: ;
            endcase
            // colour token done: hold red/green, emit pixel on blue
            if (w_apply) begin
                case (r_ch)
                    2'd0: begin
                        r_red <= w_val; r_ch <= 2'd1;
                    end
                    2'd1: begin
                        r_grn <= w_val; r_ch <= 2'd2;
                    end
                    default: begin
                        r_ch   <= 2'd0;
                        r_q[0] <= w_pix; r_n <= 2'd1;
                        r_left <= w_left_nx;
                        if (w_left_nx == 25'd0) r_ph <= PH_DONE;
                    end
                endcase
            end
        end
    end
endmodule

// ----- sv/ppm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_div: restoring divider for colour scaling
// Quotient clamped to 255; nine compare/subtract steps, then a registered done strobe.
// ----------------------------------------------------------------------------
module ppm_div import ppm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    // first step tests quotient >= 256 (saturation), then bits 7..0
    logic [39:0] r_rem;
    logic [39:0] r_dsr;
    logic [8:0]  r_q;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic        w_ge;

    assign w_ge = (r_rem >= r_dsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd8;
                r_rem  <= i_req.dividend;
                r_dsr  <= {1'b0, i_req.divisor, 8'd0};
                r_q    <= '0;
            end else if (r_busy) begin
                if (w_ge) r_rem <= r_rem - r_dsr;
                r_q   <= {r_q[7:0], w_ge};
                r_dsr <= {1'b0, r_dsr[39:1]};
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 4'd1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q[8] ? 8'hFF : r_q[7:0];
endmodule

// ----- bench/ppm_ascii_image_decoder_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_ascii_image_decoder_unit_tb: self-checking bench for the P3 decoder
// Streams directed and random PPM text through the byte channel, predicts
// every header, pixel and error item, and compares them in order.
// ----------------------------------------------------------------------------
module ppm_ascii_image_decoder_unit_tb import ppm_pkg::*; ();

// Scoreboard: a byte-level decoder predictor plus the queue of pending items.
class ppm_scoreboard;

    t_phase      phase;
    t_tmode      tmode;
    logic [1:0]  magic_st;
    bit          neg, seen_digit, digits_done, ovf;
    logic [31:0] mag;
    logic [12:0] img_w, img_h;
    logic [30:0] max_val;
    logic [24:0] px_left;
    logic [1:0]  chan;
    logic [7:0]  r_hold, g_hold;

    t_out pending_items[$];
    int   n_errors;
    int   n_items_ok;
    int   n_pixels, n_headers, n_error_items;

    function new();
        clear();
        n_errors = 0;
        n_items_ok = 0;
        n_pixels = 0;
        n_headers = 0;
        n_error_items = 0;
    endfunction

    function void clear();
        phase = PH_MAGIC;
        tmode = TM_BETWEEN;
        magic_st = 0;
        neg = 0; seen_digit = 0; digits_done = 0; ovf = 0;
        mag = 0;
        img_w = 0; img_h = 0; max_val = 0; px_left = 0;
        chan = 0; r_hold = 0; g_hold = 0;
    endfunction

    function void push_error(t_err code, ref t_out items[$]);
        t_out r;
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = code;
        items.insert(items.size(), r);
        phase = PH_DONE;
    endfunction

    function void feed_char(logic [7:0] c, bit first);
        bit is_digit;
        logic [35:0] acc;
        is_digit = (c >= "0" && c <= "9");
        if (first)
            magic_st = (c == "P") ? 2'd1 : 2'd3;
        else
            magic_st = (magic_st == 2'd1 && c == "3") ? 2'd2 : 2'd3;
        if (first && (c == "+" || c == "-")) begin
            neg = (c == "-");
            return;
        end
        if (digits_done)
            return;
        if (!is_digit) begin
            digits_done = 1;
            return;
        end
        seen_digit = 1;
        if (!ovf) begin
            acc = 36'(mag) * 10 + 36'(c - 8'h30);
            if (acc > 36'(LIMIT_NEG))
                ovf = 1;
            else
                mag = acc[31:0];
        end
    endfunction

    function logic [7:0] scaled();
        logic [63:0] q;
        logic [31:0] m;
        m = (max_val != 0) ? 32'(max_val) : 32'd1;
        if (neg || mag == 0)
            return 8'd0;
        q = 64'(mag) * 255 / 64'(m);
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function void end_token(ref t_out items[$]);
        bit ok;
        t_out r;
        logic [7:0] b;
        ok = seen_digit && !ovf && (neg || mag < 32'h8000_0000);
        if (phase == PH_MAGIC) begin
            if (magic_st == 2'd2)
                phase = PH_WIDTH;
            else
                push_error(ERR_MAGIC, items);
        end else if (phase == PH_WIDTH || phase == PH_HEIGHT || phase == PH_MAX) begin
            if (!ok)
                push_error(ERR_NUMBER, items);
            else if (neg || mag == 0)
                push_error(ERR_NONPOS, items);
            else if (phase != PH_MAX && mag > MAX_DIM)
                push_error(ERR_LARGE, items);
            else if (phase == PH_WIDTH) begin
                img_w = mag[12:0];
                phase = PH_HEIGHT;
            end else if (phase == PH_HEIGHT) begin
                img_h = mag[12:0];
                phase = PH_MAX;
            end else begin
                max_val = mag[30:0];
                px_left = 25'(img_w) * 25'(img_h);
                chan = 0;
                phase = PH_PIXELS;
                r = '0;
                r.kind = KIND_HEADER;
                r.width_out = img_w;
                r.height_out = img_h;
                items.insert(items.size(), r);
            end
        end else if (phase == PH_PIXELS) begin
            if (!ok)
                push_error(ERR_NUMBER, items);
            else if (chan == 0) begin
                r_hold = scaled();
                chan = 1;
            end else if (chan == 1) begin
                g_hold = scaled();
                chan = 2;
            end else begin
                b = scaled();
                chan = 0;
                r = '0;
                r.kind = KIND_PIXEL;
                r.red = r_hold;
                r.green = g_hold;
                r.blue = b;
                r.alpha = (r_hold == 0 && g_hold == 0 && b == 0) ? 8'd0 : 8'd255;
                if (px_left > 0)
                    px_left--;
                if (px_left == 0) begin
                    r.final_pixel = 1;
                    phase = PH_DONE;
                end
                items.insert(items.size(), r);
            end
        end
    endfunction

    // Note one accepted byte and queue the items it causes.
    function void note_byte(t_in b);
        t_out items[$];
        logic [7:0] c;
        bit ws;
        c = b.data_byte;
        ws = (c == " ") || (c >= 8'd9 && c <= 8'd13);
        case (tmode)
            TM_BETWEEN: begin
                if (!ws) begin
                    if (c == "#")
                        tmode = TM_COMMENT;
                    else begin
                        neg = 0; seen_digit = 0; digits_done = 0; ovf = 0; mag = 0;
                        feed_char(c, 1);
                        tmode = TM_TOKEN;
                    end
                end
            end
            TM_TOKEN: begin
                if (ws) begin
                    end_token(items);
                    tmode = TM_BETWEEN;
                end else
                    feed_char(c, 0);
            end
            TM_COMMENT: begin
                if (ws)
                    tmode = (c == 8'h0a) ? TM_BETWEEN : TM_SKIPLINE;
            end
            default: begin
                if (c == 8'h0a)
                    tmode = TM_BETWEEN;
            end
        endcase
        if (b.last_byte) begin
            if (tmode == TM_TOKEN)
                end_token(items);
            if (phase != PH_DONE)
                push_error(ERR_TRUNC, items);
            clear();
        end
        if (items.size() > 0)
            items[items.size() - 1].run_end = 1;
        foreach (items[i])
            pending_items.insert(pending_items.size(), items[i]);
    endfunction

    // Compare one result item with the oldest expectation.
    function void check_item(t_out got);
        t_out exp_item;
        if (pending_items.size() == 0) begin
            $display("%0t: unexpected item %h", $time, got);
            n_errors++;
            return;
        end
        exp_item = pending_items.pop_front();
        if (got !== exp_item) begin
            $display("%0t: mismatch expected kind=%0d rgba=%h_%h_%h_%h w=%0d h=%0d fin=%0d err=%0d end=%0d",
                     $time, exp_item.kind, exp_item.red, exp_item.green, exp_item.blue,
                     exp_item.alpha, exp_item.width_out, exp_item.height_out,
                     exp_item.final_pixel, exp_item.error_code, exp_item.run_end);
            $display("%0t:          actual   kind=%0d rgba=%h_%h_%h_%h w=%0d h=%0d fin=%0d err=%0d end=%0d",
                     $time, got.kind, got.red, got.green, got.blue, got.alpha,
                     got.width_out, got.height_out, got.final_pixel, got.error_code,
                     got.run_end);
            n_errors++;
        end else
            n_items_ok++;
        case (got.kind)
            KIND_PIXEL:  n_pixels++;
            KIND_HEADER: n_headers++;
            default:     n_error_items++;
        endcase
    endfunction
endclass

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;

    ppm_in_if  byte_ch ();
    ppm_out_if item_ch ();

    ppm_ascii_image_decoder_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (byte_ch.sink),
        .o_out  (item_ch.source)
    );

    always #1 i_clk = ~i_clk;

    ppm_scoreboard sb = new();

    int  send_idle_pct  = 0;   // sender gap chance, percent
    int  recv_stall_pct = 0;   // receiver stall chance, percent
    int  hold_off       = 0;   // long receiver hold-off, cycles
    int  idle_count     = 0;
    int  bytes_sent     = 0;
    byte text_buf[$];

    initial begin
        byte_ch.valid = 0;
        byte_ch.data  = '0;
        item_ch.ready = 0;
    end

    // Receiver: ready picked at each falling edge; long hold-off counted here.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            item_ch.ready <= 0;
        end else
            item_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Sample results and watch for progress at each rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (item_ch.valid && item_ch.ready)
                sb.check_item(item_ch.data);
            if ((item_ch.valid && item_ch.ready) || (byte_ch.valid && byte_ch.ready))
                idle_count <= 0;
            else if (idle_count >= WATCHDOG_LIMIT) begin
                $display("ppm_ascii_image_decoder_unit_tb failed");
                $finish;
            end else
                idle_count <= idle_count + 1;
        end
    end

    // Offer one byte, with a random gap first, and wait for its acceptance.
    // Valid stays up after acceptance; the next byte or a pause replaces it.
    task automatic send_byte(byte c, bit last);
        t_in b;
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 0;
            @(negedge i_clk);
        end
        b.data_byte = c;
        b.last_byte = last;
        byte_ch.valid <= 1;
        byte_ch.data  <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        sb.note_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Send the buffered text; last byte carries the end-of-file mark.
    task automatic flush_text();
        foreach (text_buf[i])
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.insert(text_buf.size(), s[i]);
    endtask

    function automatic string ws_sep();
        case ($urandom_range(9))
            0: return "\t";
            1: return "\n";
            2: return "\r\n";
            3: return "  ";
            4: return "\v";
            5: return "\f";
            default: return " ";
        endcase
    endfunction

    // Random well-formed file with tiny dimensions, occasionally corrupted.
    task automatic put_random_file();
        int w, h, mx, npx;
        w  = $urandom_range(1, 3);
        h  = $urandom_range(1, 2);
        mx = ($urandom_range(3) == 0) ? $urandom_range(1, 70000) : $urandom_range(1, 255);
        npx = w * h;
        if ($urandom_range(4) == 0) npx = npx - 1;           // truncated
        put_str("P3");
        put_str(ws_sep());
        if ($urandom_range(5) == 0) begin
            put_str("# note ");
            text_buf.insert(text_buf.size(), byte'($urandom_range(32, 126)));
            put_str("\n");
        end
        put_str($sformatf("%0d", w)); put_str(ws_sep());
        put_str($sformatf("%0d", h)); put_str(ws_sep());
        put_str($sformatf("%0d", mx)); put_str(ws_sep());
        for (int p = 0; p < npx * 3; p++) begin
            case ($urandom_range(19))
                0: put_str($sformatf("-%0d", $urandom_range(300)));
                1: put_str($sformatf("+%0dx", $urandom_range(mx * 2)));
                2: put_str("q");                              // bad number
                default: put_str($sformatf("%0d", $urandom_range(mx + mx / 4)));
            endcase
            put_str(ws_sep());
        end
        if ($urandom_range(3) == 0)
            text_buf.insert(text_buf.size(), byte'($urandom_range(255)));  // noise byte
        if (text_buf.size() == 0) put_str(" ");
    endtask

    // Stop offering and wait until every expected item has come.
    task automatic drain();
        byte_ch.valid <= 0;
        while (sb.pending_items.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_idling(int s, int r);
        send_idle_pct  = s;
        recv_stall_pct = r;
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: header extremes, comments, error codes, truncation.
        put_str("P3 # c\n1 1 255\n0 0 0\n");  flush_text();            // black pixel
        put_str("P3\t4096\n1\n1\n2 0 1 ");      flush_text();           // max width
        put_str("P3 1 1 2147483647 2147483647 -5 +9x"); flush_text();
        put_str("P4 ");                          flush_text();           // bad magic
        put_str("P3 4097 ");                     flush_text();           // too large
        put_str("P3 0 ");                        flush_text();           // nonpositive
        put_str("P3 2147483648 ");               flush_text();           // overflow
        put_str("P3 -x ");                       flush_text();           // no digits
        put_str("P3 1 -2147483648 ");            flush_text();
        put_str("P3 2 2 9 1 2 3");               flush_text();           // truncated
        text_buf.insert(text_buf.size(), 8'hff);
        text_buf.insert(text_buf.size(), 8'h00); flush_text();
        text_buf.insert(text_buf.size(), 8'h80);
        text_buf.insert(text_buf.size(), 8'h7f); flush_text();
        put_str("P3#\r1 1 1 1 1 1");             flush_text();
        drain();

        // Random files across idling phases.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_idling(0, 0);
                1: set_idling(77, 0);
                2: set_idling(0, 77);
                default: set_idling(27, 27);
            endcase
            while (bytes_sent < 350 + ph * 350) begin
                put_random_file();
                flush_text();
            end
            if (ph == 1) begin
                // Long receiver hold-off while bytes keep coming.
                set_idling(0, 0);
                hold_off = 300;
                put_str("P3 3 2 255 1 2 3 4 5 6 7 8 9 1 2 3 4 5 6 7 8 9 ");
                flush_text();
            end
            drain();
        end

        $display("Covered %0d bytes: %0d headers, %0d pixels, %0d error items checked.",
                 bytes_sent, sb.n_headers, sb.n_pixels, sb.n_error_items);
        $display("%0d items matched under idle, stall and long hold-off phases.",
                 sb.n_items_ok);
        if (sb.n_errors == 0)
            $display("ppm_ascii_image_decoder_unit_tb passed");
        else
            $display("ppm_ascii_image_decoder_unit_tb failed");
        $finish;
    end
endmodule
